// File: rtl/core/uripec_pkg.sv
// shared types, character constants and helpers for the uri percent-encode canonicaliser
package uripec_pkg;

    localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
    localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] HIGH_BIT = 8'h80;
    localparam logic [3:0] NIB_MASK = 4'hF;

    localparam logic [1:0] KIND_USERINFO = 2'd0;
    localparam logic [1:0] KIND_PATH     = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;
    localparam logic [1:0] KIND_ZONE_ID  = 2'd3;

    localparam logic [1:0] KIND_RESET = KIND_PATH;

    // classification of one byte
    typedef struct packed {
        logic       allowed;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       pct;
    } cls_t;

    // one output byte with its flags
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
        logic       bad_escape;
    } res_t;

    // nibble to uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [3:0] m;
        m = v & NIB_MASK;
        if (m < 4'd10)
            hex_char = 8'h30 + {4'd0, m};
        else
            hex_char = 8'h41 + {4'd0, m} - 8'd10;
    endfunction

endpackage

// File: rtl/core/uripec_classify.sv
// byte classifier: allowed set for the component kind, hex digit decode
module uripec_classify
    import uripec_pkg::*;
(
    input  logic [7:0] byte_in,
    input  logic [1:0] kind,
    output cls_t       cls
);

    logic alnum;
    logic unres_sub;
    logic extra;

    always_comb
    begin
        alnum = (byte_in >= 8'h41 && byte_in <= 8'h5A) ||
                (byte_in >= 8'h61 && byte_in <= 8'h7A) ||
                (byte_in >= 8'h30 && byte_in <= 8'h39);

        // unreserved marks and sub-delimiters
        case (byte_in)
            8'h2D, 8'h2E, 8'h5F, CH_TILDE,
            8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: unres_sub = 1'b1;
            default:                           unres_sub = 1'b0;
        endcase

        case (kind)
            KIND_USERINFO: extra = (byte_in == CH_COLON);
            KIND_PATH:     extra = (byte_in == CH_COLON) || (byte_in == CH_AT) ||
                                   (byte_in == CH_SLASH);
            KIND_QUERY:    extra = (byte_in == CH_COLON) || (byte_in == CH_AT) ||
                                   (byte_in == CH_SLASH) || (byte_in == CH_QUEST);
            default:       extra = 1'b0;
        endcase

        cls.allowed = (byte_in < HIGH_BIT) && (alnum || unres_sub || extra);
        cls.pct     = (byte_in == CH_PCT);

        if (byte_in >= 8'h30 && byte_in <= 8'h39)
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = byte_in[3:0];
        end
        else if ((byte_in >= 8'h61 && byte_in <= 8'h66) ||
                 (byte_in >= 8'h41 && byte_in <= 8'h46))
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = 4'd9 + byte_in[3:0];
        end
        else
        begin
            cls.hex_ok  = 1'b0;
            cls.hex_val = 4'd0;
        end
    end

endmodule

// File: rtl/core/uri_percent_encode_canonicalizer.sv
// top level of the uri percent-encode canonicaliser
// One byte of a URI component is taken per request on the slave side and its canonical
// form leaves on the master side, one byte per cycle while m_tready is high: an allowed
// byte passes through as one result, a byte outside the allowed set or a re-emitted %hh
// escape leaves as three results ('%' and two uppercase hex digits), a malformed or
// truncated escape leaves one error result with bad_escape set and the rest of that
// string is swallowed up to its last byte. An input request is classified and expanded
// in the same cycle into a small result buffer of up to three entries; the buffer drains
// one entry per cycle while the sink is ready. The next request is taken in the cycle the
// buffer's final entry leaves, or while it is empty, so passthrough text streams at one
// byte per cycle while the sink is ready. The drain port of the result buffer sets the
// rate. The user must write component_kind through the cfg channel only while idle; the
// block itself does not enforce it. component_kind resets to path.
module uri_percent_encode_canonicalizer
    import uripec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,      // component_kind
    // input bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] in_byte
    input  logic       s_tlast,       // last_of_string
    // canonical output bytes
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [7:0] out_byte
    output logic       m_tlast,       // run_last
    output logic [1:0] m_tuser        // [0] string_end, [1] bad_escape
);

    typedef enum logic [1:0] {
        PH_NORMAL,
        PH_PCT,
        PH_HIGH,
        PH_DISCARD
    } phase_t;

    logic [1:0] kind_reg;
    phase_t     phase_reg, phase_next;
    logic [3:0] hn_reg, hn_next;
    logic [1:0] cnt_reg, cnt_next;
    res_t       res_reg [3];
    res_t       res_next [3];

    cls_t       cls;
    logic       in_acc;
    logic       out_acc;
    logic       last;
    logic [7:0] trip_val;
    res_t       gen [3];
    logic [1:0] gen_n;

    uripec_classify u_cls (
        .byte_in (s_tdata),
        .kind    (kind_reg),
        .cls     (cls)
    );

    // configuration is always taken
    assign cfg_ready = 1'b1;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = res_reg[0].data;
    assign m_tlast  = res_reg[0].run_last;
    assign m_tuser  = {res_reg[0].bad_escape, res_reg[0].string_end};

    assign out_acc  = m_tvalid && m_tready;
    // a new request once the buffer empties in this cycle
    assign s_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign last     = s_tlast;

    // expand one input byte into its results and the next escape phase
    always_comb
    begin
        phase_next = phase_reg;
        hn_next    = hn_reg;
        gen_n      = 2'd0;
        gen[0]     = '0;
        gen[1]     = '0;
        gen[2]     = '0;
        trip_val   = (phase_reg == PH_HIGH) ? {hn_reg, cls.hex_val} : s_tdata;

        if (in_acc)
        begin
            case (phase_reg)
                PH_NORMAL:
                begin
                    if (cls.pct)
                    begin
                        if (last)
                        begin
                            gen_n  = 2'd1;
                            gen[0] = '{data: 8'd0, run_last: 1'b1, string_end: 1'b1,
                                       bad_escape: 1'b1};
                            hn_next = 4'd0;
                        end
                        else
                        begin
                            phase_next = PH_PCT;
                        end
                    end
                    else if (cls.allowed)
                    begin
                        gen_n  = 2'd1;
                        gen[0] = '{data: s_tdata, run_last: 1'b1, string_end: last,
                                   bad_escape: 1'b0};
                    end
                    else
                    begin
                        gen_n = 2'd3;
                    end
                end
                PH_PCT:
                begin
                    if (!cls.hex_ok || last)
                    begin
                        gen_n      = 2'd1;
                        gen[0]     = '{data: 8'd0, run_last: 1'b1, string_end: last,
                                       bad_escape: 1'b1};
                        phase_next = last ? PH_NORMAL : PH_DISCARD;
                        hn_next    = 4'd0;
                    end
                    else
                    begin
                        hn_next    = cls.hex_val;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    hn_next = 4'd0;
                    if (!cls.hex_ok)
                    begin
                        gen_n      = 2'd1;
                        gen[0]     = '{data: 8'd0, run_last: 1'b1, string_end: last,
                                       bad_escape: 1'b1};
                        phase_next = last ? PH_NORMAL : PH_DISCARD;
                    end
                    else
                    begin
                        gen_n      = 2'd3;
                        phase_next = PH_NORMAL;
                    end
                end
                default:
                begin
                    if (last)
                        phase_next = PH_NORMAL;
                end
            endcase

            // triplet form: '%' then high and low hex digits
            if (gen_n == 2'd3)
            begin
                gen[0] = '{data: CH_PCT, run_last: 1'b0, string_end: 1'b0,
                           bad_escape: 1'b0};
                gen[1] = '{data: hex_char(trip_val[7:4]), run_last: 1'b0,
                           string_end: 1'b0, bad_escape: 1'b0};
                gen[2] = '{data: hex_char(trip_val[3:0]), run_last: 1'b1,
                           string_end: last, bad_escape: 1'b0};
            end
        end
    end

    // result buffer: load on a request, otherwise shift one entry out per beat
    always_comb
    begin
        cnt_next    = cnt_reg;
        res_next[0] = res_reg[0];
        res_next[1] = res_reg[1];
        res_next[2] = res_reg[2];
        if (in_acc)
        begin
            cnt_next    = gen_n;
            res_next[0] = gen[0];
            res_next[1] = gen[1];
            res_next[2] = gen[2];
        end
        else if (out_acc)
        begin
            cnt_next    = cnt_reg - 2'd1;
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_RESET;
            phase_reg <= PH_NORMAL;
            hn_reg    <= 4'd0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind_reg <= cfg_data;
            phase_reg <= phase_next;
            hn_reg    <= hn_next;
            cnt_reg   <= cnt_next;
        end
    end

    // payload of the result buffer, no reset needed
    always_ff @(posedge clk)
    begin
        res_reg[0] <= res_next[0];
        res_reg[1] <= res_next[1];
        res_reg[2] <= res_next[2];
    end

    // a full buffer held off by the sink keeps its head byte
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3 || !$past(cnt_reg == 2'd3 && !m_tready) || $stable(m_tdata))
        else $error("result buffer changed while stalled");

    // an error or string-closing byte always ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tlast)
        else $error("string_end or bad_escape without run_last");

    // a request is only taken when the buffer is empty or drains its last entry in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_acc))
        else $error("request taken while results still pending");

    // a discarded string cannot produce output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && phase_reg == PH_DISCARD |=> cnt_reg == 2'd0)
        else $error("output produced while discarding");

endmodule
